[rtl/pgrw_pkg.sv]
// Shared types, codes and constants of the planar glyph reveal writer.
package pgrw_pkg;

    // Font and framebuffer geometry
    localparam int unsigned GLYPH_ROWS  = 8;
    localparam int unsigned ROW_BYTES   = 80;
    localparam int unsigned MAP_DEPTH   = 256;
    localparam int unsigned GLYPH_DEPTH = 1024;

    // Request kinds
    localparam logic [1:0] KIND_DRAW  = 2'd0;
    localparam logic [1:0] KIND_MAP   = 2'd1;
    localparam logic [1:0] KIND_GLYPH = 2'd2;

    // Reveal colors
    localparam logic [7:0] COLOR_CURSOR = 8'hff;
    localparam logic [7:0] COLOR_NEXT   = 8'hfe;
    localparam logic [7:0] COLOR_OLDER  = 8'hfd;

    // Input request
    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  table_index;
        logic [7:0]  table_data;
        logic [7:0]  character;
        logic [7:0]  char_slot;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [15:0] char_address;
        logic [15:0] reveal_cursor;
    } item_t;

    // One result
    typedef struct packed {
        logic [15:0] write_address;
        logic [1:0]  plane;
        logic [7:0]  pixel_color;
        logic        stop;
        logic        last;
    } result_t;

    // Table write request
    typedef struct packed {
        logic       map_we;
        logic       glyph_we;
        logic [9:0] addr;
        logic [7:0] data;
    } tbl_wr_t;

    // Draw sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_FETCH,
        ST_EMIT
    } seq_state_t;

    // Byte offset of a glyph row below the character's top row
    function automatic logic [15:0] row_start_bytes(input logic [2:0] row);
        return 16'(32'(row) * ROW_BYTES);
    endfunction

endpackage

[rtl/planar_glyph_reveal_writer_core.sv]
// A stop result is registered and shows in the cycle after its request is accepted. A draw
// reads the map, then the eight glyph rows on the single glyph memory port, then walks the 64
// bit positions up to the last set one, giving a write for each set bit; busy stays high
// throughout, so no new request is taken until the draw is done. An empty glyph ends after
// the row reads, a hidden glyph after the map read; stop draws and loads do not raise busy.
// Results cannot be stalled. Reset clears the sequencer and frame_base; the map and glyph
// memories hold garbage until loaded.
module planar_glyph_reveal_writer_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pgrw_pkg::item_t   item,
    output logic              result_valid,
    output pgrw_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    logic              accept;
    logic              draw_accept;
    logic [15:0]       frame_base_reg;
    pgrw_pkg::tbl_wr_t tbl_wr;
    logic [7:0]        map_rd_addr;
    logic [7:0]        map_rd_data;
    logic [9:0]        glyph_rd_addr;
    logic [7:0]        glyph_rd_data;

    assign accept      = start && !busy;
    assign draw_accept = accept && (item.kind == pgrw_pkg::KIND_DRAW);

    // Frame base register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            frame_base_reg <= cfg_data;
        end
    end

    // Table loads; map loads beyond 255 are dropped
    assign tbl_wr.map_we   = accept && (item.kind == pgrw_pkg::KIND_MAP)
                           && (item.table_index[9:8] == 2'd0);
    assign tbl_wr.glyph_we = accept && (item.kind == pgrw_pkg::KIND_GLYPH);
    assign tbl_wr.addr     = item.table_index;
    assign tbl_wr.data     = item.table_data;

    pgrw_tables u_tables
    (
        .clk           (clk),
        .wr            (tbl_wr),
        .map_rd_addr   (map_rd_addr),
        .map_rd_data   (map_rd_data),
        .glyph_rd_addr (glyph_rd_addr),
        .glyph_rd_data (glyph_rd_data)
    );

    pgrw_seq u_seq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .draw_accept   (draw_accept),
        .item          (item),
        .frame_base    (frame_base_reg),
        .busy          (busy),
        .map_rd_addr   (map_rd_addr),
        .map_rd_data   (map_rd_data),
        .glyph_rd_addr (glyph_rd_addr),
        .glyph_rd_data (glyph_rd_data),
        .result_valid  (result_valid),
        .result        (result)
    );

endmodule

[rtl/pgrw_tables.sv]
// Character map and glyph row memories, one write and one registered read each.
module pgrw_tables
(
    input  logic              clk,
    input  pgrw_pkg::tbl_wr_t wr,
    input  logic [7:0]        map_rd_addr,
    output logic [7:0]        map_rd_data,
    input  logic [9:0]        glyph_rd_addr,
    output logic [7:0]        glyph_rd_data
);

    logic [7:0] map_mem   [pgrw_pkg::MAP_DEPTH];
    logic [7:0] glyph_mem [pgrw_pkg::GLYPH_DEPTH];

    // Character map port
    always_ff @(posedge clk)
    begin
        if (wr.map_we)
        begin
            map_mem[wr.addr[7:0]] <= wr.data;
        end
        map_rd_data <= map_mem[map_rd_addr];
    end

    // Glyph row port
    always_ff @(posedge clk)
    begin
        if (wr.glyph_we)
        begin
            glyph_mem[wr.addr] <= wr.data;
        end
        glyph_rd_data <= glyph_mem[glyph_rd_addr];
    end

endmodule

[rtl/pgrw_seq.sv]
// Draw sequencer: map lookup, glyph row fetch and a framebuffer write for each set glyph bit.
module pgrw_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              draw_accept,
    input  pgrw_pkg::item_t   item,
    input  logic [15:0]       frame_base,
    output logic              busy,
    output logic [7:0]        map_rd_addr,
    input  logic [7:0]        map_rd_data,
    output logic [9:0]        glyph_rd_addr,
    input  logic [7:0]        glyph_rd_data,
    output logic              result_valid,
    output pgrw_pkg::result_t result
);

    pgrw_pkg::seq_state_t state_reg, state_next;

    logic [2:0]       row_cnt_reg, row_cnt_next;
    logic [6:0]       gidx_reg, gidx_next;
    logic [7:0][7:0]  rows_reg, rows_next;
    logic [63:0]      pend_reg, pend_next;
    logic [5:0]       pos_reg, pos_next;
    logic [15:0]      base_reg, base_next;
    logic [7:0]       color_reg, color_next;
    logic [1:0]       xpl_reg, xpl_next;
    pgrw_pkg::result_t result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic [15:0]      reveal_gap;
    logic             dist_neg;
    logic [7:0][7:0]  rows_cap;
    logic [63:0]      mask;
    logic             emit_last;

    // Reveal distance of the incoming request
    assign reveal_gap = item.reveal_cursor - item.char_address;
    assign dist_neg   = reveal_gap[15];

    // Row capture and write mask; bit order is plane step, row, left/right
    assign rows_cap = {glyph_rd_data, rows_reg[7:1]};

    always_comb
    begin
        logic [5:0] kk;
        logic [1:0] ps;
        logic [2:0] bsel;
        mask = '0;
        for (int k = 0; k < 64; k++)
        begin
            kk   = 6'(k);
            ps   = kk[5:4];
            bsel = kk[0] ? (3'd3 - {1'b0, ps}) : (3'd7 - {1'b0, ps});
            mask[k] = rows_cap[kk[3:1]][bsel];
        end
    end

    assign emit_last = (pend_reg[63:1] == 63'd0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pgrw_pkg::ST_IDLE:
            begin
                if (draw_accept && !dist_neg)
                begin
                    state_next = pgrw_pkg::ST_MAP;
                end
            end
            pgrw_pkg::ST_MAP:
            begin
                state_next = map_rd_data[7] ? pgrw_pkg::ST_IDLE : pgrw_pkg::ST_FETCH;
            end
            pgrw_pkg::ST_FETCH:
            begin
                if (row_cnt_reg == 3'd7)
                begin
                    state_next = (mask == 64'd0) ? pgrw_pkg::ST_IDLE : pgrw_pkg::ST_EMIT;
                end
            end
            pgrw_pkg::ST_EMIT:
            begin
                if (pend_reg[0] && emit_last)
                begin
                    state_next = pgrw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pgrw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        logic [2:0] pl_sum;
        row_cnt_next      = row_cnt_reg;
        gidx_next         = gidx_reg;
        rows_next         = rows_reg;
        pend_next         = pend_reg;
        pos_next          = pos_reg;
        base_next         = base_reg;
        color_next        = color_reg;
        xpl_next          = xpl_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        glyph_rd_addr     = {gidx_reg, row_cnt_reg + 3'd1};
        pl_sum            = {1'b0, xpl_reg} + {1'b0, pos_reg[5:4]};

        case (state_reg)
            pgrw_pkg::ST_IDLE:
            begin
                if (draw_accept)
                begin
                    base_next = frame_base
                              + 16'(32'(item.y) * pgrw_pkg::ROW_BYTES)
                              + 16'(item.x[8:2])
                              + {7'd0, item.char_slot, 1'b0};
                    xpl_next  = item.x[1:0];
                    case (reveal_gap[7:0])
                        8'd0:    color_next = pgrw_pkg::COLOR_CURSOR;
                        8'd1:    color_next = pgrw_pkg::COLOR_NEXT;
                        default: color_next = pgrw_pkg::COLOR_OLDER;
                    endcase
                    // Not yet revealed: single stop result
                    if (dist_neg)
                    begin
                        result_next       = '{write_address: 16'd0, plane: 2'd0,
                                              pixel_color: 8'd0, stop: 1'b1, last: 1'b1};
                        result_valid_next = 1'b1;
                    end
                end
            end
            pgrw_pkg::ST_MAP:
            begin
                gidx_next     = map_rd_data[6:0];
                glyph_rd_addr = {map_rd_data[6:0], 3'd0};
                row_cnt_next  = 3'd0;
            end
            pgrw_pkg::ST_FETCH:
            begin
                rows_next    = rows_cap;
                row_cnt_next = row_cnt_reg + 3'd1;
                pend_next    = mask;
                pos_next     = 6'd0;
            end
            pgrw_pkg::ST_EMIT:
            begin
                if (pend_reg[0])
                begin
                    result_next.write_address = base_reg + {15'd0, pl_sum[2]}
                                              + pgrw_pkg::row_start_bytes(pos_reg[3:1])
                                              + {15'd0, pos_reg[0]};
                    result_next.plane       = pl_sum[1:0];
                    result_next.pixel_color = color_reg;
                    result_next.stop        = 1'b0;
                    result_next.last        = emit_last;
                    result_valid_next       = 1'b1;
                end
                pend_next = {1'b0, pend_reg[63:1]};
                pos_next  = pos_reg + 6'd1;
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pgrw_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        row_cnt_reg <= row_cnt_next;
        gidx_reg    <= gidx_next;
        rows_reg    <= rows_next;
        pend_reg    <= pend_next;
        pos_reg     <= pos_next;
        base_reg    <= base_next;
        color_reg   <= color_next;
        xpl_reg     <= xpl_next;
        result_reg  <= result_next;
    end

    assign busy         = (state_reg != pgrw_pkg::ST_IDLE);
    assign map_rd_addr  = item.character;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/pgrw_checker.sv]
// Port-level checks of the glyph writer, bound to the top level.
module pgrw_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input pgrw_pkg::result_t result
);

    // A stop result always carries the last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stop |-> result.last)
        else $error("stop result without last");

    // A stop result carries no write
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.stop |->
            (result.write_address == 16'd0) && (result.plane == 2'd0)
            && (result.pixel_color == 8'd0))
        else $error("stop result with write fields");

    // Writes use one of the three reveal colors
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.stop |->
            (result.pixel_color == pgrw_pkg::COLOR_CURSOR)
            || (result.pixel_color == pgrw_pkg::COLOR_NEXT)
            || (result.pixel_color == pgrw_pkg::COLOR_OLDER))
        else $error("write with bad color");

    // Results only follow an accepted request or busy work
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy) || $past(start && !busy))
        else $error("result out of nowhere");

endmodule

bind planar_glyph_reveal_writer_core pgrw_checker u_pgrw_checker (.*);

[dv/pgrw_tb_pkg.sv]
// Write tracker for the glyph reveal writer bench: predicts framebuffer writes and checks them.
`timescale 1ns / 1ps
package pgrw_tb_pkg;
    import pgrw_pkg::*;

    class glyph_write_book;
        logic [7:0]  char_map [MAP_DEPTH];
        logic [7:0]  glyph_rows [GLYPH_DEPTH];
        logic [15:0] frame_base;
        result_t     writes_due [$];
        int          errors;

        function new();
            frame_base = '0;
            errors     = 0;
        endfunction

        function void set_frame_base(input logic [15:0] value);
            frame_base = value;
        endfunction

        // Apply one accepted request: table loads update the copies, draws queue their writes
        function void note_request(input item_t req);
            logic [15:0] gap;
            logic [7:0]  color;
            logic [7:0]  glyph;
            logic [7:0]  bits;
            logic [15:0] base;
            logic [15:0] addr;
            logic [2:0]  lane;
            int          first;
            int          p;
            int          row;
            result_t     w;
            case (req.kind)
                KIND_MAP:
                begin
                    if (req.table_index < MAP_DEPTH)
                        char_map[req.table_index[7:0]] = req.table_data;
                end
                KIND_GLYPH:
                begin
                    glyph_rows[req.table_index] = req.table_data;
                end
                KIND_DRAW:
                begin
                    gap = req.reveal_cursor - req.char_address;
                    // not yet revealed: single stop write, nothing else
                    if (gap[15])
                    begin
                        w      = '0;
                        w.stop = 1'b1;
                        w.last = 1'b1;
                        writes_due.push_back(w);
                        return;
                    end
                    if (gap[7:0] == 8'd0)
                        color = COLOR_CURSOR;
                    else if (gap[7:0] == 8'd1)
                        color = COLOR_NEXT;
                    else
                        color = COLOR_OLDER;
                    glyph = char_map[req.character];
                    // hidden glyph
                    if (glyph[7])
                        return;
                    base = 16'(32'(frame_base) + 32'(req.y) * ROW_BYTES
                               + 32'(req.x[8:2]) + 32'(req.char_slot) * 2);
                    first = writes_due.size();
                    for (p = 0; p < 4; p++)
                    begin
                        lane = 3'(req.x[1:0]) + 3'(p);
                        addr = base + 16'(lane[2]);
                        for (row = 0; row < GLYPH_ROWS; row++)
                        begin
                            bits          = glyph_rows[10'(32'(glyph) * GLYPH_ROWS + row)];
                            w             = '0;
                            w.plane       = lane[1:0];
                            w.pixel_color = color;
                            if (bits[7 - p])
                            begin
                                w.write_address = addr;
                                writes_due.push_back(w);
                            end
                            if (bits[3 - p])
                            begin
                                w.write_address = addr + 16'd1;
                                writes_due.push_back(w);
                            end
                            addr = addr + 16'(ROW_BYTES);
                        end
                    end
                    // flag the final write of this draw
                    if (writes_due.size() > first)
                    begin
                        w      = writes_due[writes_due.size() - 1];
                        w.last = 1'b1;
                        writes_due[writes_due.size() - 1] = w;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compare one observed write with the oldest predicted one
        function void check_write(input result_t got);
            result_t want;
            if (writes_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: unexpected write addr %h plane %0d color %h stop %b last %b",
                             got.write_address, got.plane, got.pixel_color, got.stop, got.last);
                return;
            end
            want = writes_due.pop_front();
            if (got.write_address !== want.write_address || got.plane !== want.plane
                || got.pixel_color !== want.pixel_color || got.stop !== want.stop
                || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: got  addr %h plane %0d color %h stop %b last %b",
                             got.write_address, got.plane, got.pixel_color, got.stop, got.last);
                    $display("          want addr %h plane %0d color %h stop %b last %b",
                             want.write_address, want.plane, want.pixel_color, want.stop,
                             want.last);
                end
            end
        endfunction
    endclass

endpackage

[dv/planar_glyph_reveal_writer_core_test.sv]
// Top-level bench for the glyph reveal writer: drives loads and draws, checks every write.
`timescale 1ns / 1ps
module planar_glyph_reveal_writer_core_test;
    import pgrw_pkg::*;
    import pgrw_tb_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT   = 1000;
    localparam int         SETTLE_CYCLES = 100;
    localparam int         PHASE_ITEMS   = 60;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    item_t       item      = '0;
    logic        result_valid;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    glyph_write_book book;
    int              quiet_cycles = 0;
    int              sent_count   = 0;
    bit              idle_on      = 1'b1;

    // what the stimulus has loaded so far, so draws only touch written entries
    bit         map_set [MAP_DEPTH];
    logic [7:0] map_shadow [MAP_DEPTH];
    bit         row_set [GLYPH_DEPTH];

    planar_glyph_reveal_writer_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Monitor: record accepted requests, check writes, watchdog on quiet cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                book.note_request(item);
            if (result_valid)
                book.check_write(result);
        end
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic item_t random_request();
        item_t r;
        r.kind          = 2'($urandom);
        r.table_index   = 10'($urandom);
        r.table_data    = 8'($urandom);
        r.character     = 8'($urandom);
        r.char_slot     = 8'($urandom);
        r.x             = 9'($urandom_range(319));
        r.y             = 8'($urandom_range(239));
        r.char_address  = 16'($urandom);
        r.reveal_cursor = 16'($urandom);
        return r;
    endfunction

    function automatic bit drawable(input logic [7:0] c);
        int r;
        if (!map_set[c])
            return 1'b0;
        for (r = 0; r < GLYPH_ROWS; r++)
            if (!row_set[10'(32'(map_shadow[c]) * GLYPH_ROWS + r)])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] random_map_value();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255, 128));
        return 8'($urandom_range(127));
    endfunction

    // Present one request, with optional idle cycles before it; returns at the accepting edge
    task automatic send_request(input item_t req);
        if (idle_on && $urandom_range(99) < 38)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 38)
                @(posedge clk);
        end
        start <= 1'b1;
        item  <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue(input item_t req);
        if (req.kind == KIND_MAP && req.table_index < MAP_DEPTH)
        begin
            map_set[req.table_index[7:0]]    = 1'b1;
            map_shadow[req.table_index[7:0]] = req.table_data;
            sent_count++;
        end
        else if (req.kind == KIND_GLYPH)
        begin
            row_set[req.table_index] = 1'b1;
            sent_count++;
        end
        else if (req.kind == KIND_DRAW)
        begin
            sent_count++;
        end
        send_request(req);
    endtask

    task automatic issue_load(input logic [1:0] kind, input logic [9:0] idx,
                              input logic [7:0] data);
        item_t r;
        r             = random_request();
        r.kind        = kind;
        r.table_index = idx;
        r.table_data  = data;
        issue(r);
    endtask

    task automatic issue_draw(input logic [7:0] c, input logic [7:0] slot, input logic [8:0] x,
                              input logic [7:0] y, input logic [15:0] caddr,
                              input logic [15:0] cursor);
        item_t r;
        r               = random_request();
        r.kind          = KIND_DRAW;
        r.character     = c;
        r.char_slot     = slot;
        r.x             = x;
        r.y             = y;
        r.char_address  = caddr;
        r.reveal_cursor = cursor;
        issue(r);
    endtask

    task automatic issue_random_draw(input logic [7:0] c);
        logic [15:0] caddr;
        logic [15:0] gap;
        caddr = 16'($urandom);
        case ($urandom_range(7))
            0: gap = 16'd0;
            1: gap = 16'd1;
            2: gap = 16'd2;
            3: gap = 16'($urandom_range(255, 3));
            4, 5: gap = 16'($urandom_range(16'h7fff, 256));
            6: gap = 16'($urandom_range(16'hffff, 16'h8000));
            default: gap = $urandom_range(1) ? 16'h7fff : 16'hffff;
        endcase
        issue_draw(c, 8'($urandom), 9'($urandom_range(319)), 8'($urandom_range(239)),
                   caddr, caddr + gap);
    endtask

    // Well-formed sequence: map a character, fill its glyph rows, draw it a few times
    task automatic load_and_draw();
        logic [7:0] c;
        logic [7:0] v;
        logic [7:0] data;
        int         r;
        c = 8'($urandom);
        v = random_map_value();
        issue_load(KIND_MAP, 10'(c), v);
        for (r = 0; r < GLYPH_ROWS; r++)
        begin
            case ($urandom_range(7))
                0: data = 8'h00;
                1: data = 8'hff;
                default: data = 8'($urandom);
            endcase
            issue_load(KIND_GLYPH, 10'(32'(v) * GLYPH_ROWS + r), data);
        end
        repeat ($urandom_range(3, 1))
            issue_random_draw(c);
    endtask

    task automatic run_random(input int goal);
        int         stop_at;
        int         pick;
        int         tries;
        bit         found;
        logic [7:0] c;
        stop_at = sent_count + goal;
        while (sent_count < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                // ignored requests
                if ($urandom_range(1))
                    issue_load(KIND_UNUSED, 10'($urandom), 8'($urandom));
                else
                    issue_load(KIND_MAP, 10'($urandom_range(1023, 256)), 8'($urandom));
            end
            else if (pick < 20)
            begin
                if ($urandom_range(1))
                    issue_load(KIND_MAP, 10'($urandom_range(255)), random_map_value());
                else
                    issue_load(KIND_GLYPH, 10'($urandom), 8'($urandom));
            end
            else if (pick < 45)
            begin
                load_and_draw();
            end
            else
            begin
                found = 1'b0;
                c     = '0;
                for (tries = 0; tries < 16 && !found; tries++)
                begin
                    c     = 8'($urandom);
                    found = drawable(c);
                end
                if (found)
                    issue_random_draw(c);
                else
                    load_and_draw();
            end
        end
    endtask

    // Wait for the block to go quiet with every predicted write seen
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (busy || book.writes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic program_frame_base(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        book.set_frame_base(value);
    endtask

    initial
    begin
        logic [15:0] bases [4];
        int          ph;
        book  = new();
        bases = '{16'hffff, 16'($urandom), 16'h0000, 16'hff80};

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, frame_base at its reset value
        issue_load(KIND_MAP, 10'h041, 8'h01);
        for (int r = 0; r < GLYPH_ROWS; r++)
            issue_load(KIND_GLYPH, 10'(8 + r), 8'hff);
        issue_draw(8'h41, 8'd0, 9'd0, 8'd0, 16'h1234, 16'h1234);
        issue_draw(8'h41, 8'd255, 9'd319, 8'd239, 16'hffff, 16'h0000);
        issue_draw(8'h41, 8'd7, 9'd2, 8'd5, 16'h0000, 16'h7fff);
        issue_draw(8'h41, 8'd1, 9'd1, 8'd1, 16'h0000, 16'h8000);
        issue_draw(8'h41, 8'd2, 9'd3, 8'd9, 16'h0100, 16'h00ff);
        // empty glyph, then a hidden one whose rows alias the empty glyph
        issue_load(KIND_MAP, 10'h0ff, 8'h00);
        for (int r = 0; r < GLYPH_ROWS; r++)
            issue_load(KIND_GLYPH, 10'(r), 8'h00);
        issue_draw(8'hff, 8'd3, 9'd100, 8'd100, 16'h0010, 16'h0010);
        issue_load(KIND_MAP, 10'h080, 8'h80);
        issue_draw(8'h80, 8'd4, 9'd200, 8'd50, 16'h0010, 16'h0011);
        // out-of-range map load and unused kind must leave the tables alone
        issue_load(KIND_MAP, 10'h341, 8'h7f);
        issue_load(KIND_UNUSED, 10'h041, 8'h02);
        issue_draw(8'h41, 8'd0, 9'd3, 8'd0, 16'h4000, 16'h4002);
        settle();

        // Random phases under several frame bases; one phase runs without idling
        for (ph = 0; ph < 4; ph++)
        begin
            program_frame_base(bases[ph]);
            idle_on = (ph != 2);
            run_random(PHASE_ITEMS);
            settle();
        end

        if (book.writes_due.size() != 0)
        begin
            $display("mismatch: %0d predicted writes never arrived", book.writes_due.size());
            book.errors++;
        end
        if (book.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
